FILE: src/rlim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlim_pkg
// Shared types and register codes for the raster line index map.
// ----------------------------------------------------------------------------
package rlim_pkg;

	// Width of the register index on the configuration port.
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_LEN = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_LEN = 2'd1;

	// Setup sequencer that derives the divide constants from the line lengths.
	typedef enum logic [2:0] {
		ST_START,
		ST_DIV_LEN,
		ST_THR,
		ST_DIV_RQ,
		ST_DIV_RQ1,
		ST_IDLE
	} cfg_state_t;

	// Line geometry flags, taken straight from the length registers.
	typedef struct packed {
		logic eq;
		logic grow;
		logic src_zero;
		logic tgt_zero;
	} mode_t;

endpackage

FILE: src/raster_line_index_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_line_index_map
// Nearest-neighbour resampling index generator: maps a pixel position on a
// source line to the matching position on a target line.
// ----------------------------------------------------------------------------
//
// Channel   Handshake             Payload
// in        in_valid / in_stall   position
// out       out_valid / out_stall mapped_index, beyond_source
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One position word is taken per clock while in_stall is low, and its result
// word leaves through the four-stage datapath, whose two multipliers each
// own a stage.
// After reset and after every configuration write the setup sequencer runs
// three restoring divisions on one shared divider, and in_stall stays high
// until they are done.
// A stall on the output holds the last stage, and the hold reaches back to
// the first empty stage, so no word is lost or repeated.
//
// How it works: when shrinking, the quotient q and remainder r of the line
// lengths, the split point r*(q+1), and the reciprocals 2^N/q and 2^N/(q+1)
// are derived once. Each position then picks its divisor, multiplies by the
// rounded-down reciprocal, and fixes the estimate with one back product and
// compare. When growing, the same multiplier forms q*x and the stage after
// adds min(x, r).
// ----------------------------------------------------------------------------
module raster_line_index_map #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rlim_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [COORD_BITS-1:0]               position,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [COORD_BITS-1:0]               mapped_index,
	output logic                                beyond_source
);
	import rlim_pkg::*;

	// Geometry flags and derived constants; the user keeps these stable while words are in flight (not enforced).
	mode_t                 mode;
	logic                  cfg_busy;
	logic [COORD_BITS-1:0] src_len;
	logic [COORD_BITS-1:0] q;
	logic [COORD_BITS-1:0] r;
	logic [COORD_BITS-1:0] thr;
	logic [COORD_BITS:0]   recip_q;
	logic [COORD_BITS:0]   recip_q1;

	// Length registers and the divide sequencer.
	rlim_cfg #(.N(COORD_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (cfg_busy),
		.mode      (mode),
		.src_len   (src_len),
		.q         (q),
		.r         (r),
		.thr       (thr),
		.recip_q   (recip_q),
		.recip_q1  (recip_q1)
	);

	// Per-position datapath.
	rlim_pipe #(.N(COORD_BITS)) u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_busy      (cfg_busy),
		.mode          (mode),
		.src_len       (src_len),
		.q             (q),
		.r             (r),
		.thr           (thr),
		.recip_q       (recip_q),
		.recip_q1      (recip_q1),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.position      (position),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.mapped_index  (mapped_index),
		.beyond_source (beyond_source)
	);

endmodule

FILE: src/rlim_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlim_divider
// Restoring divider, one quotient bit per cycle, used by the setup sequencer.
// ----------------------------------------------------------------------------
module rlim_divider #(
	parameter int W = 17
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int CNT_BITS = $clog2(W + 1);

	logic [W-1:0]        rem_q;
	logic [W-1:0]        quo_q;
	logic [W-1:0]        dvs_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_BITS'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

FILE: src/rlim_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlim_cfg
// Length registers and the setup sequencer that derives quotient, remainder,
// split threshold and the two reciprocals used by the datapath.
// ----------------------------------------------------------------------------
module rlim_cfg #(
	parameter int N = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rlim_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [N-1:0]                          cfg_data,
	output logic                                  busy,
	output rlim_pkg::mode_t                       mode,
	output logic [N-1:0]                          src_len,
	output logic [N-1:0]                          q,
	output logic [N-1:0]                          r,
	output logic [N-1:0]                          thr,
	output logic [N:0]                            recip_q,
	output logic [N:0]                            recip_q1
);
	import rlim_pkg::*;

	localparam int W = N + 1;
	localparam logic [W-1:0] TWO_POW_N = {1'b1, {N{1'b0}}};

	cfg_state_t state_q, state_d;

	logic [N-1:0] src_q, tgt_q;
	logic [N-1:0] q_q, r_q, thr_q;
	logic [W-1:0] recip_q_q, recip_q1_q;

	logic         cfg_wr;
	logic [N-1:0] big, small_len;
	logic         div_start;
	logic [W-1:0] div_dividend, div_divisor;
	logic         div_done;
	logic [W-1:0] div_quot, div_rem;
	logic [W-1:0] q_plus1;
	logic [N+W-1:0] thr_full;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign mode.eq       = src_q == tgt_q;
	assign mode.grow     = src_q < tgt_q;
	assign mode.src_zero = src_q == '0;
	assign mode.tgt_zero = tgt_q == '0;

	// The longer line is always divided by the shorter one.
	assign big       = mode.grow ? tgt_q : src_q;
	assign small_len = mode.grow ? src_q : tgt_q;
	assign q_plus1   = {1'b0, q_q} + W'(1);
	assign thr_full  = r_q * q_plus1;

	rlim_divider #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			src_q   <= N'(1);
			tgt_q   <= N'(1);
		end else begin
			state_q <= state_d;
			if (cfg_wr && cfg_index == REG_SOURCE_LEN) begin
				src_q <= cfg_data;
			end
			if (cfg_wr && cfg_index == REG_TARGET_LEN) begin
				tgt_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_LEN && div_done) begin
			q_q <= div_quot[N-1:0];
			r_q <= div_rem[N-1:0];
		end
		if (state_q == ST_THR) begin
			thr_q <= thr_full[N-1:0];
		end
		if (state_q == ST_DIV_RQ && div_done) begin
			recip_q_q <= div_quot;
		end
		if (state_q == ST_DIV_RQ1 && div_done) begin
			recip_q1_q <= div_quot;
		end
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = TWO_POW_N;
		div_divisor  = {1'b0, q_q};
		case (state_q)
			ST_START: begin
				div_start    = 1'b1;
				div_dividend = {1'b0, big};
				div_divisor  = {1'b0, small_len};
				state_d      = ST_DIV_LEN;
			end
			ST_DIV_LEN: begin
				if (div_done) begin
					state_d = ST_THR;
				end
			end
			ST_THR: begin
				div_start = 1'b1;
				state_d   = ST_DIV_RQ;
			end
			ST_DIV_RQ: begin
				if (div_done) begin
					div_start   = 1'b1;
					div_divisor = q_plus1;
					state_d     = ST_DIV_RQ1;
				end
			end
			ST_DIV_RQ1: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_START;
			end
		endcase
		// A new length always restarts the derivation.
		if (cfg_wr) begin
			state_d = ST_START;
		end
	end

	assign busy     = state_q != ST_IDLE;
	assign src_len  = src_q;
	assign q        = q_q;
	assign r        = r_q;
	assign thr      = thr_q;
	assign recip_q  = recip_q_q;
	assign recip_q1 = recip_q1_q;

endmodule

FILE: src/rlim_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlim_pipe
// Four-stage index datapath: operand select, reciprocal product, back
// product, remainder correction and result select.
// ----------------------------------------------------------------------------
module rlim_pipe #(
	parameter int N = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_busy,
	input  rlim_pkg::mode_t mode,
	input  logic [N-1:0]    src_len,
	input  logic [N-1:0]    q,
	input  logic [N-1:0]    r,
	input  logic [N-1:0]    thr,
	input  logic [N:0]      recip_q,
	input  logic [N:0]      recip_q1,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [N-1:0]    position,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [N-1:0]    mapped_index,
	output logic            beyond_source
);
	import rlim_pkg::*;

	localparam int W = N + 1;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic accept;

	// Stage 1 operands.
	logic         sel_hi;
	logic [N-1:0] xn;
	logic [N-1:0] x_s1, xn_s1, a_s1, minxr_s1;
	logic [W-1:0] b_s1, dvs_s1;
	logic         beyond_s1;

	// Stage 2 product.
	logic [N+W-1:0] prod_s2;
	logic [N-1:0]   x_s2, xn_s2, minxr_s2;
	logic [W-1:0]   dvs_s2;
	logic           beyond_s2;

	// Stage 3 back product.
	logic [N-1:0]   qe;
	logic [N+W-1:0] qd_full;
	logic [N-1:0]   qe_s3, qd_s3, xn_s3, x_s3, grow_s3;
	logic [W-1:0]   dvs_s3;
	logic           beyond_s3;

	// Stage 4 correction.
	logic [N-1:0] rem;
	logic         corr;
	logic [N-1:0] shr;
	logic [N-1:0] result;
	logic [N-1:0] idx_s4;
	logic         beyond_s4;

	assign rdy_s4   = !v_s4 || !out_stall;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = cfg_busy || !rdy_s1;
	assign accept   = in_valid && !in_stall;

	assign sel_hi = position < thr;
	assign xn     = sel_hi ? position : position - r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= accept;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			x_s1      <= position;
			xn_s1     <= xn;
			beyond_s1 <= position >= src_len;
			minxr_s1  <= (position < r) ? position : r;
			a_s1      <= mode.grow ? position : xn;
			b_s1      <= mode.grow ? {1'b0, q} : (sel_hi ? recip_q1 : recip_q);
			dvs_s1    <= sel_hi ? ({1'b0, q} + W'(1)) : {1'b0, q};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			prod_s2   <= a_s1 * b_s1;
			x_s2      <= x_s1;
			xn_s2     <= xn_s1;
			minxr_s2  <= minxr_s1;
			dvs_s2    <= dvs_s1;
			beyond_s2 <= beyond_s1;
		end
	end

	// The reciprocal is rounded down, so the estimate is low by at most one.
	assign qe      = prod_s2[2*N-1:N];
	assign qd_full = qe * dvs_s2;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			qe_s3     <= qe;
			qd_s3     <= qd_full[N-1:0];
			xn_s3     <= xn_s2;
			x_s3      <= x_s2;
			grow_s3   <= prod_s2[N-1:0] + minxr_s2;
			dvs_s3    <= dvs_s2;
			beyond_s3 <= beyond_s2;
		end
	end

	assign rem  = xn_s3 - qd_s3;
	assign corr = {1'b0, rem} >= dvs_s3;
	assign shr  = qe_s3 + {{(N-1){1'b0}}, corr};

	always_comb begin
		if (beyond_s3) begin
			result = '1;
		end else if (mode.tgt_zero) begin
			result = '0;
		end else if (mode.eq) begin
			result = x_s3;
		end else if (mode.grow) begin
			result = grow_s3;
		end else begin
			result = shr;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			idx_s4    <= result;
			beyond_s4 <= beyond_s3;
		end
	end

	assign out_valid     = v_s4;
	assign mapped_index  = idx_s4;
	assign beyond_source = beyond_s4;

endmodule

FILE: verif/rlim_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlim_checker
// Watches the configuration, position and result channels of the raster line
// index map, keeps its own copy of the line lengths, works out the expected
// target index for every accepted position and compares it with the result
// words in order.
// ----------------------------------------------------------------------------
module rlim_checker #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [rlim_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [COORD_BITS-1:0]               position,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [COORD_BITS-1:0]               mapped_index,
	input  logic                                beyond_source,
	output int                                  mismatches,
	output int                                  outstanding
);

	import rlim_pkg::*;

	typedef struct packed {
		logic [COORD_BITS-1:0] index;
		logic                  beyond;
	} target_pixel_t;

	target_pixel_t          expected_pixels[$];
	logic [COORD_BITS-1:0]  src_len_copy;
	logic [COORD_BITS-1:0]  tgt_len_copy;
	int                     mismatch_count = 0;
	int                     waiting_count = 0;

	assign mismatches  = mismatch_count;
	assign outstanding = waiting_count;

	function automatic target_pixel_t nearest_target(
		input logic [COORD_BITS-1:0] x,
		input logic [COORD_BITS-1:0] src,
		input logic [COORD_BITS-1:0] tgt
	);
		logic [63:0]   m;
		logic [63:0]   n;
		logic [63:0]   xv;
		logic [63:0]   q;
		logic [63:0]   r;
		logic [63:0]   idx;
		logic [63:0]   top;
		target_pixel_t res;
		m   = 64'(src);
		n   = 64'(tgt);
		xv  = 64'(x);
		top = (64'd1 << COORD_BITS) - 64'd1;
		if (xv >= m) begin
			res.index  = '1;
			res.beyond = 1'b1;
			return res;
		end
		if (n == 0) begin
			idx = 0;
		end else if (m == n) begin
			idx = xv;
		end else if (m > n) begin
			// Shrinking: the first r target pixels cover q+1 source pixels each.
			q = m / n;
			r = m % n;
			if (r == 0)
				idx = xv / q;
			else if (xv < r * (q + 1))
				idx = xv / (q + 1);
			else
				idx = (xv - r) / q;
		end else begin
			q   = n / m;
			r   = n % m;
			idx = q * xv + ((xv < r) ? xv : r);
		end
		if (idx > top)
			idx = top;
		res.index  = idx[COORD_BITS-1:0];
		res.beyond = 1'b0;
		return res;
	endfunction

	// All channel signals change only just after a rising edge, so the values
	// seen at the falling edge are the ones the next rising edge acts on.
	always @(negedge clk or negedge arst_n) begin
		target_pixel_t want;
		if (!arst_n) begin
			src_len_copy = 1;
			tgt_len_copy = 1;
			expected_pixels.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SOURCE_LEN)
					src_len_copy = cfg_data;
				else if (cfg_index == REG_TARGET_LEN)
					tgt_len_copy = cfg_data;
			end
			if (in_valid && !in_stall)
				expected_pixels.push_back(nearest_target(position, src_len_copy,
					tgt_len_copy));
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result word with nothing expected: index %0d beyond %0b",
							$realtime, mapped_index, beyond_source);
				end else begin
					want = expected_pixels.pop_front();
					if (mapped_index !== want.index || beyond_source !== want.beyond) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch: expected index %0d beyond %0b, got index %0d beyond %0b",
								$realtime, want.index, want.beyond, mapped_index, beyond_source);
					end
				end
			end
		end
		waiting_count = expected_pixels.size();
	end

	final begin
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the raster line index map. It programs line lengths, feeds
// position words under varying back pressure and leaves prediction and
// comparison to the checker, which reports a mismatch count for the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	import rlim_pkg::*;

	localparam int COORD_BITS = 16;
	localparam int MAX_COORD  = (1 << COORD_BITS) - 1;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_SOURCE_LEN;
	logic [COORD_BITS-1:0]     cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [COORD_BITS-1:0]     position = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [COORD_BITS-1:0]     mapped_index;
	logic                      beyond_source;

	int mismatches;
	int outstanding;

	// Idle rates in percent for the two sides; the stimulus process moves
	// them through the three idling regimes.
	int send_gap_pct   = 13;
	int result_hold_pct = 45;

	// The line lengths last programmed, used to aim positions at the valid
	// range of the source line.
	int src_len_now = 1;
	int tgt_len_now = 1;

	raster_line_index_map #(
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.position     (position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mapped_index (mapped_index),
		.beyond_source(beyond_source)
	);

	rlim_checker #(
		.COORD_BITS(COORD_BITS)
	) checker_inst (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.position     (position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mapped_index (mapped_index),
		.beyond_source(beyond_source),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// The result side holds off at random, drawn fresh every cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < result_hold_pct);
	end

	// Offers one position word, with a random gap in front, and returns at the
	// rising edge that accepts it. The stall seen at the falling edge is the
	// one that edge acts on.
	task automatic send_position(input int x);
		bit taken;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		position <= x[COORD_BITS-1:0];
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Stops sending and waits until every result word has come back. Each
	// position makes exactly one result, so an empty checker queue means the
	// pipeline is empty.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Returns at the edge that takes the write and leaves cfg_valid high, so
	// a following write can go out in the very next cycle; the caller drops
	// cfg_valid after the last write.
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[COORD_BITS-1:0];
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Reprograms both line lengths with the block idle. The setup pass that
	// follows a write shows up as in_stall and is waited out by the sender.
	task automatic set_lengths(input int src, input int tgt);
		drain_results();
		write_reg(REG_SOURCE_LEN, src);
		write_reg(REG_TARGET_LEN, tgt);
		cfg_valid <= 1'b0;
		src_len_now = src;
		tgt_len_now = tgt;
	endtask

	// Line lengths lean on the ends of the range and on small values, where
	// the remainder handling is easiest to get wrong.
	function automatic int pick_length();
		case ($urandom_range(5))
			0:       return 1;
			1:       return MAX_COORD;
			2:       return $urandom_range(16, 2);
			3:       return $urandom_range(1000, 17);
			default: return $urandom_range(MAX_COORD, 1);
		endcase
	endfunction

	// Most positions fall on the source line; some sit on its last pixel, on
	// the first pixel past it, around the point where a shrink switches from
	// q+1 to q source pixels per target pixel, or anywhere in the field.
	function automatic int pick_position();
		int q;
		int r;
		int split;
		case ($urandom_range(11))
			0:       return $urandom_range(MAX_COORD);
			1:       return src_len_now - 1;
			2:       return src_len_now;
			3:       return 0;
			4: begin
				if (src_len_now > tgt_len_now) begin
					q     = src_len_now / tgt_len_now;
					r     = src_len_now % tgt_len_now;
					split = r * (q + 1) - $urandom_range(1);
					if (split >= 0 && split < src_len_now)
						return split;
				end
				return $urandom_range(src_len_now - 1);
			end
			default: return $urandom_range(src_len_now - 1);
		endcase
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words. Reset leaves both lengths at one pixel.
		send_position(0);
		send_position(1);
		send_position(MAX_COORD);

		// Equal lengths pass the position through, up to the largest line.
		set_lengths(MAX_COORD, MAX_COORD);
		send_position(0);
		send_position('h5555);
		send_position('hAAAA);
		send_position(MAX_COORD - 1);
		send_position(MAX_COORD);

		// Shrink to a single pixel, an exact division.
		set_lengths(MAX_COORD, 1);
		send_position(0);
		send_position(MAX_COORD - 1);
		send_position(MAX_COORD);

		// Shrink with a remainder: 100 over 7 gives two pixels of 15 and five
		// of 14, so the switch falls at position 30.
		set_lengths(100, 7);
		send_position(29);
		send_position(30);
		send_position(31);
		send_position(99);
		send_position(100);

		// Growing from a single pixel to the largest line.
		set_lengths(1, MAX_COORD);
		send_position(0);
		send_position(1);

		// Growing with a remainder: 7 to 100 gives two extra pixels on the
		// first two source pixels.
		set_lengths(7, 100);
		send_position(0);
		send_position(1);
		send_position(2);
		send_position(6);
		send_position(7);

		// Random part: eight settings of a hundred words each, through the
		// three idling regimes.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 3) begin
				send_gap_pct    = 13;
				result_hold_pct = 45;
			end else if (ph < 6) begin
				send_gap_pct    = 45;
				result_hold_pct = 13;
			end else begin
				send_gap_pct    = 0;
				result_hold_pct = 0;
			end
			set_lengths(pick_length(), pick_length());
			for (int k = 0; k < 100; k++) begin
				// Once, the sender holds back until the pipeline has emptied.
				if (ph == 4 && k == 50)
					drain_results();
				send_position(pick_position());
			end
		end

		drain_results();
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
